@@ design/byte_entropy_estimator_defines.svh @@
// Assertion helpers for the RTL.
`ifndef BYTE_ENTROPY_ESTIMATOR_DEFINES_SVH
`define BYTE_ENTROPY_ESTIMATOR_DEFINES_SVH

// Same-cycle implication.
`define BEE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define BEE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/bee_pkg.sv @@
`default_nettype none
package bee_pkg;

  localparam int BIN_W       = 8;
  localparam int OUT_FRAC    = 12;
  localparam int ENTROPY_MAX = 32768;
  localparam int THR_W       = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

  typedef struct packed {
    logic ready;
    logic accept;
    logic clr_wr;
    logic inc_wr;
    logic walk_rd;
    logic walk_log;
    logic walk_mul;
    logic walk_acc;
    logic nlog;
    logic div_step;
    logic out_load;
  } bee_cmd_t;

  typedef struct packed {
    logic sat;
    logic last_in;
    logic last;
    logic addr_last;
    logic div_done;
    logic out_free;
  } bee_sts_t;

endpackage
`default_nettype wire

@@ design/bee_ctrl.sv @@
`default_nettype none
`include "byte_entropy_estimator_defines.svh"
module bee_ctrl
  import bee_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire bee_sts_t sts_i,
  output bee_cmd_t      cmd_o
);

  typedef enum logic [9:0] {
    S_CLR  = 10'b00_0000_0001,
    S_IDLE = 10'b00_0000_0010,
    S_INC  = 10'b00_0000_0100,
    S_RD   = 10'b00_0000_1000,
    S_LOG  = 10'b00_0001_0000,
    S_MUL  = 10'b00_0010_0000,
    S_ACC  = 10'b00_0100_0000,
    S_NLOG = 10'b00_1000_0000,
    S_DIV  = 10'b01_0000_0000,
    S_OUT  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.addr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.ready  = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (!sts_i.sat) state_d = S_INC;
          else if (sts_i.last_in) state_d = S_RD;
        end
      end
      S_INC: begin
        cmd_o.inc_wr = 1'b1;
        state_d = sts_i.last ? S_RD : S_IDLE;
      end
      S_RD: begin
        cmd_o.walk_rd = 1'b1;
        state_d = S_LOG;
      end
      S_LOG: begin
        cmd_o.walk_log = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.walk_mul = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.walk_acc = 1'b1;
        state_d = sts_i.addr_last ? S_NLOG : S_RD;
      end
      S_NLOG: begin
        cmd_o.nlog = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLR;
    endcase
  end

  `BEE_ASSERT_NEXT(a_load_to_idle, cmd_o.out_load, state_q == S_IDLE)
  `BEE_ASSERT_NOW(a_one_writer, 1'b1, $onehot0({cmd_o.clr_wr, cmd_o.inc_wr, cmd_o.walk_log}))
  `BEE_ASSERT_NEXT(a_inc_after_accept, cmd_o.accept && !sts_i.sat, state_q == S_INC)

endmodule
`default_nettype wire

@@ design/bee_dp.sv @@
`default_nettype none
module bee_dp
  import bee_pkg::*;
#(
  parameter int COUNT_BITS      = 24,
  parameter int LOG_FRAC_BITS   = 12,
  parameter int MANT_TABLE_BITS = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire bee_cmd_t         cmd_i,
  output bee_sts_t              sts_o,
  input  wire logic [BIN_W-1:0] data_byte_i,
  input  wire logic             last_byte_i,
  input  wire logic             cfg_we_i,
  input  wire logic [THR_W-1:0] cfg_wdata_i,
  input  wire logic             out_stall_i,
  output logic                  out_valid_o,
  output logic [15:0]           entropy_q4_12_o,
  output logic                  above_threshold_o,
  output logic                  count_overflow_o
);

  localparam int F     = LOG_FRAC_BITS;
  localparam int M     = MANT_TABLE_BITS;
  localparam int CB    = COUNT_BITS;
  localparam int LOG_W = F + $clog2(CB + 1);
  localparam int S_W   = CB + LOG_W;
  localparam int H_W   = S_W + 1;
  localparam int U_W   = H_W + 4;
  localparam int TAB_N = 1 << M;
  localparam int TAB_W = F + 1;
  localparam int P_W   = $clog2(CB);
  localparam int DC_W  = $clog2(S_W);
  localparam int SHR   = (F > OUT_FRAC) ? F - OUT_FRAC : 0;
  localparam int SHL   = (F < OUT_FRAC) ? OUT_FRAC - F : 0;
  localparam int NBINS = 1 << BIN_W;

  typedef logic [TAB_W-1:0] tab_t [TAB_N];

  // log2(1 + m/2^M) by repeated squaring in Q2.62, rounded half up
  function automatic tab_t build_tab();
    logic [63:0]    x;
    logic [127:0]   pr;
    logic [TAB_W:0] acc;
    tab_t           t;
    for (int m = 0; m < TAB_N; m++) begin
      x   = (64'd1 << 62) + (64'(m) << (62 - M));
      acc = '0;
      for (int k = 0; k < F + 1; k++) begin
        pr  = {64'd0, x} * {64'd0, x};
        x   = pr[125:62];
        acc = {acc[TAB_W-1:0], 1'b0};
        if (x[63]) begin
          acc[0] = 1'b1;
          x = x >> 1;
        end
      end
      t[m] = TAB_W'((acc + 1'b1) >> 1);
    end
    return t;
  endfunction

  localparam tab_t LOG_TAB = build_tab();

  function automatic logic [LOG_W-1:0] log2_fix(input logic [CB-1:0] x);
    logic [P_W-1:0]  p;
    logic [CB+M-1:0] xs;
    logic [M-1:0]    m;
    logic [LOG_W-1:0] r;
    p = '0;
    for (int i = 0; i < CB; i++) begin
      if (x[i]) p = P_W'(i);
    end
    xs = {x, {M{1'b0}}} >> p;
    m  = xs[M-1:0];
    r  = (LOG_W'(p) << F) + LOG_W'(LOG_TAB[m]);
    if (x == '0) r = '0;
    return r;
  endfunction

  logic [CB-1:0]    mem [NBINS];
  logic [CB-1:0]    rd_q;
  logic [BIN_W-1:0] byte_q, addr_q;
  logic             last_q;
  logic [CB-1:0]    total_q, c_q, rem_q;
  logic             ovf_q;
  logic [LOG_W-1:0] lg_q;
  logic [S_W-1:0]   prod_q, sum_q, quo_q;
  logic [DC_W-1:0]  dcnt_q;
  logic [THR_W-1:0] thr_q;
  logic             out_valid_q, above_q, ovf_out_q;
  logic [15:0]      ent_q;

  logic             mem_we, mem_re;
  logic [BIN_W-1:0] mem_wa, mem_ra;
  logic [CB-1:0]    mem_wd, lg_in;
  logic [CB:0]      div_sh;
  logic             div_ge;
  logic [H_W-1:0]   h;
  logic [U_W-1:0]   u;
  logic [15:0]      q;

  assign mem_we = cmd_i.clr_wr | cmd_i.inc_wr | cmd_i.walk_log;
  assign mem_wa = cmd_i.inc_wr ? byte_q : addr_q;
  assign mem_wd = cmd_i.inc_wr ? rd_q + 1'b1 : '0;
  assign mem_re = cmd_i.accept | cmd_i.walk_rd;
  assign mem_ra = cmd_i.accept ? data_byte_i : addr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra];
  end

  assign lg_in  = cmd_i.nlog ? total_q : rd_q;
  assign div_sh = {rem_q, quo_q[S_W-1]};
  assign div_ge = div_sh >= {1'b0, total_q};

  assign h = H_W'(lg_q) - H_W'(quo_q);
  assign u = (U_W'(h[H_W-2:0]) >> SHR) << SHL;
  always_comb begin
    if (h[H_W-1] || h == '0) q = '0;
    else if (u > U_W'(ENTROPY_MAX)) q = 16'(ENTROPY_MAX);
    else q = u[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      thr_q       <= THR_RESET;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      dcnt_q      <= '0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (cmd_i.clr_wr || cmd_i.walk_acc) addr_q <= addr_q + 1'b1;
      if (cmd_i.accept && sts_o.sat) ovf_q <= 1'b1;
      if (cmd_i.inc_wr) total_q <= total_q + 1'b1;
      if (cmd_i.walk_acc) sum_q <= sum_q + prod_q;
      if (cmd_i.nlog) dcnt_q <= '0;
      else if (cmd_i.div_step) dcnt_q <= dcnt_q + 1'b1;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        total_q     <= '0;
        ovf_q       <= 1'b0;
        sum_q       <= '0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.clr_wr) sum_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    if (cmd_i.walk_log || cmd_i.nlog) lg_q <= log2_fix(lg_in);
    if (cmd_i.walk_log) c_q <= rd_q;
    if (cmd_i.walk_mul) prod_q <= S_W'(c_q) * S_W'(lg_q);
    if (cmd_i.nlog) begin
      rem_q <= '0;
      quo_q <= sum_q;
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? CB'(div_sh - {1'b0, total_q}) : div_sh[CB-1:0];
      quo_q <= {quo_q[S_W-2:0], div_ge};
    end
    if (cmd_i.out_load) begin
      ent_q     <= q;
      above_q   <= q >= thr_q;
      ovf_out_q <= ovf_q;
    end
  end

  assign sts_o.sat       = total_q == {CB{1'b1}};
  assign sts_o.last_in   = last_byte_i;
  assign sts_o.last      = last_q;
  assign sts_o.addr_last = addr_q == {BIN_W{1'b1}};
  assign sts_o.div_done  = dcnt_q == DC_W'(S_W - 1);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o       = out_valid_q;
  assign entropy_q4_12_o   = ent_q;
  assign above_threshold_o = above_q;
  assign count_overflow_o  = ovf_out_q;

endmodule
`default_nettype wire

@@ design/byte_entropy_estimator.sv @@
`default_nettype none
// Shannon entropy of a byte block, unsigned Q4.12 bits per byte. Each byte
// is a read then a write back of its histogram bin, or a read alone once the
// total has saturated. A last byte then starts the result phase: a walk over
// all 256 bins (read, log2, multiply, accumulate, clearing each bin as it
// goes), log2 of the total, a restoring divider taking one quotient bit per
// cycle, and a load of the result register once the output is free. After
// reset the histogram's 256 bins are zeroed before the first byte is taken.
module byte_entropy_estimator
  import bee_pkg::*;
#(
  parameter int COUNT_BITS      = 24,
  parameter int LOG_FRAC_BITS   = 12,
  parameter int MANT_TABLE_BITS = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [BIN_W-1:0] data_byte_i,
  input  wire logic             last_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [15:0]           entropy_q4_12_o,
  output logic                  above_threshold_o,
  output logic                  count_overflow_o,
  input  wire logic             cfg_we_i,
  input  wire logic [THR_W-1:0] cfg_wdata_i
);

  bee_cmd_t cmd;
  bee_sts_t sts;

  bee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bee_dp #(
    .COUNT_BITS      (COUNT_BITS),
    .LOG_FRAC_BITS   (LOG_FRAC_BITS),
    .MANT_TABLE_BITS (MANT_TABLE_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .entropy_q4_12_o   (entropy_q4_12_o),
    .above_threshold_o (above_threshold_o),
    .count_overflow_o  (count_overflow_o)
  );

  assign in_stall_o = !cmd.ready;

endmodule
`default_nettype wire
